// File: sv/fixed_width_observation_field_parse_assert.svh
// Assertion macros shared by the observation field parser modules.
`ifndef FIXED_WIDTH_OBSERVATION_FIELD_PARSE_ASSERT_SVH
`define FIXED_WIDTH_OBSERVATION_FIELD_PARSE_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is high.
`define FWOFP_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("fwofp assertion failed");
// Clocked assertion that is checked in reset as well.
`define FWOFP_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("fwofp assertion failed");
`else
`define FWOFP_ASSERT(name, clk, rst, prop)
`define FWOFP_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: sv/fwofp_pkg.sv
// Types, constants and helper functions of the observation field parser.
`timescale 1ns / 1ps
package fwofp_pkg;

   localparam int unsigned FieldBytes   = 16;
   localparam int unsigned DigitCount   = 13;
   localparam int unsigned SignBytes    = 10;
   localparam int unsigned PointByte    = 10;
   localparam int unsigned LliByte      = 14;
   localparam int unsigned SsiByte      = 15;
   localparam int unsigned GroupScale   = 10000;
   localparam int unsigned MagScale     = 100000;
   localparam int unsigned MagWidth     = 44;
   localparam int unsigned ValueWidth   = 45;
   localparam logic [MagWidth-1:0] MaxMag = 44'd9999999999999;

   localparam logic [7:0] NewlineChar = 8'h0A;
   localparam logic [7:0] SpaceChar   = 8'h20;
   localparam logic [7:0] MinusChar   = 8'h2D;

   // Fields that ride along with the number through every stage.
   typedef struct packed {
      logic       neg;
      logic [7:0] lli_char;
      logic [7:0] ssi_char;
      logic [4:0] consumed;
      logic [7:0] slot_tag;
   } side_type;

   // Word leaving the decode stage: digits, most significant first.
   typedef struct packed {
      logic [DigitCount-1:0][3:0] digits;
      side_type                   side;
   } digit_word_type;

   // Word leaving the combine stages: unsigned magnitude.
   typedef struct packed {
      logic [MagWidth-1:0] mag;
      side_type            side;
   } mag_word_type;

   // Character to digit: bit 7 set or a nibble above 9 counts as zero.
   function automatic logic [3:0] digit_of(input logic [7:0] ch);
      logic [3:0] nib;
      nib = ch[3:0];
      if (ch[7] || (nib > 4'd9)) begin
         return 4'd0;
      end
      return nib;
   endfunction

endpackage

// File: sv/fwofp_decode.sv
// Decode stage: newline blanking, digit extraction, sign and consumed count.
`timescale 1ns / 1ps
`include "fixed_width_observation_field_parse_assert.svh"
module fwofp_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [63:0]                chars_lo,
   input  logic [63:0]                chars_hi,
   input  logic [7:0]                 slot_tag,
   output logic                       out_valid,
   input  logic                       out_ready,
   output fwofp_pkg::digit_word_type  out_word
);

   logic                      valid_ff;
   fwofp_pkg::digit_word_type word_ff;
   fwofp_pkg::digit_word_type word_in;

   // The stage takes a word when it is empty or its word leaves now.
   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   // Blank from the first newline on, then map characters to digits.
   always_comb begin
      logic [fwofp_pkg::FieldBytes-1:0][7:0] raw;
      logic [fwofp_pkg::FieldBytes-1:0][7:0] blanked;
      logic                                  seen;
      logic [4:0]                            first_nl;
      logic                                  neg;
      int                                    src;
      raw      = {chars_hi, chars_lo};
      seen     = 1'b0;
      first_nl = 5'(fwofp_pkg::FieldBytes);
      neg      = 1'b0;
      for (int i = 0; i < fwofp_pkg::FieldBytes; i++) begin
         seen       = seen || (raw[i] == fwofp_pkg::NewlineChar);
         blanked[i] = seen ? fwofp_pkg::SpaceChar : raw[i];
      end
      for (int i = fwofp_pkg::FieldBytes - 1; i >= 0; i--) begin
         if (raw[i] == fwofp_pkg::NewlineChar) begin
            first_nl = 5'(i);
         end
      end
      for (int i = 0; i < fwofp_pkg::SignBytes; i++) begin
         neg = neg || (blanked[i] == fwofp_pkg::MinusChar);
      end
      // Digit 12 is the most significant; the decimal point byte is skipped.
      for (int j = 0; j < fwofp_pkg::DigitCount; j++) begin
         src = (j < fwofp_pkg::PointByte) ? j : j + 1;
         word_in.digits[fwofp_pkg::DigitCount-1-j] = fwofp_pkg::digit_of(blanked[src]);
      end
      word_in.side.neg      = neg;
      word_in.side.lli_char = blanked[fwofp_pkg::LliByte];
      word_in.side.ssi_char = blanked[fwofp_pkg::SsiByte];
      word_in.side.consumed = first_nl;
      word_in.side.slot_tag = slot_tag;
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         word_ff <= word_in;
      end
   end

   `FWOFP_ASSERT(a_lli_blanked, clock, reset, out_valid && (out_word.side.consumed < 5'd15) |-> out_word.side.lli_char == fwofp_pkg::SpaceChar)
   `FWOFP_ASSERT(a_neg_needs_text, clock, reset, out_valid && out_word.side.neg |-> out_word.side.consumed != 5'd0)

endmodule

// File: sv/fwofp_combine.sv
// Combine stages: digits to four-digit groups, to two halves, to the magnitude.
`timescale 1ns / 1ps
`include "fixed_width_observation_field_parse_assert.svh"
module fwofp_combine (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  fwofp_pkg::digit_word_type  in_word,
   output logic                       out_valid,
   input  logic                       out_ready,
   output fwofp_pkg::mag_word_type    out_word
);

   // Group stage registers.
   logic                    grp_valid_ff;
   logic [2:0][13:0]        grp_ff;
   logic [3:0]              last_digit_ff;
   fwofp_pkg::side_type     grp_side_ff;
   logic [2:0][13:0]        grp_in;

   // Half stage registers.
   logic                    half_valid_ff;
   logic [26:0]             hi_ff;
   logic [16:0]             lo_ff;
   fwofp_pkg::side_type     half_side_ff;
   logic [26:0]             hi_in;
   logic [16:0]             lo_in;

   // Magnitude stage registers.
   logic                    mag_valid_ff;
   fwofp_pkg::mag_word_type mag_ff;
   logic [fwofp_pkg::MagWidth-1:0] mag_in;

   logic grp_en;
   logic half_en;
   logic mag_en;

   // Each stage moves when it is empty or the next one takes its word.
   assign mag_en    = !mag_valid_ff || out_ready;
   assign half_en   = !half_valid_ff || mag_en;
   assign grp_en    = !grp_valid_ff || half_en;
   assign in_ready  = grp_en;
   assign out_valid = mag_valid_ff;
   assign out_word  = mag_ff;

   // Four digits make one group below 10000.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         grp_in[k] = {10'd0, in_word.digits[12-4*k]} * 14'd1000
                   + {10'd0, in_word.digits[11-4*k]} * 14'd100
                   + {10'd0, in_word.digits[10-4*k]} * 14'd10
                   + {10'd0, in_word.digits[9-4*k]};
      end
   end

   // Upper eight digits and lower five digits.
   assign hi_in = 27'(grp_ff[0]) * 27'(fwofp_pkg::GroupScale) + 27'(grp_ff[1]);
   assign lo_in = 17'(grp_ff[2]) * 17'd10 + 17'(last_digit_ff);

   // Full 13-digit magnitude.
   assign mag_in = 44'(hi_ff) * 44'(fwofp_pkg::MagScale) + 44'(lo_ff);

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff  <= 1'b0;
         half_valid_ff <= 1'b0;
         mag_valid_ff  <= 1'b0;
      end else begin
         if (grp_en) begin
            grp_valid_ff <= in_valid;
         end
         if (half_en) begin
            half_valid_ff <= grp_valid_ff;
         end
         if (mag_en) begin
            mag_valid_ff <= half_valid_ff;
         end
      end
   end

   // Payload of the three stages.
   always_ff @(posedge clock) begin
      if (grp_en && in_valid) begin
         grp_ff        <= grp_in;
         last_digit_ff <= in_word.digits[0];
         grp_side_ff   <= in_word.side;
      end
      if (half_en && grp_valid_ff) begin
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
         half_side_ff <= grp_side_ff;
      end
      if (mag_en && half_valid_ff) begin
         mag_ff.mag  <= mag_in;
         mag_ff.side <= half_side_ff;
      end
   end

   `FWOFP_ASSERT(a_mag_in_range, clock, reset, out_valid |-> out_word.mag <= fwofp_pkg::MaxMag)

endmodule

// File: sv/fixed_width_observation_field_parse.sv
// Top level of the fixed-width observation field parser.
`timescale 1ns / 1ps
`include "fixed_width_observation_field_parse_assert.svh"
// Parses one 16-character observation field per word into a signed 13-digit
// integer (decimal point at byte 10 dropped), the loss-of-lock and signal
// strength characters, and the newline position. A new word is taken every
// cycle while the result side does not stall. Each word passes five registers
// (decode, group, half, magnitude and sign) before its result is presented.
// The per-stage multiply by a constant sets the cycle.
module fixed_width_observation_field_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [63:0]         req_chars_lo,
   input  logic [63:0]         req_chars_hi,
   input  logic [7:0]          req_slot_tag,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [44:0]  rsp_value,
   output logic [7:0]          rsp_lli_char,
   output logic [7:0]          rsp_ssi_char,
   output logic [4:0]          rsp_consumed,
   output logic [7:0]          rsp_slot_tag_out
);

   logic                      dec_valid;
   logic                      dec_ready;
   fwofp_pkg::digit_word_type dec_word;
   logic                      mag_valid;
   logic                      mag_ready;
   fwofp_pkg::mag_word_type   mag_word;

   logic                                    valid_ff;
   logic signed [fwofp_pkg::ValueWidth-1:0] value_ff;
   fwofp_pkg::side_type                     side_ff;
   logic signed [fwofp_pkg::ValueWidth-1:0] value_in;

   fwofp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .chars_lo  (req_chars_lo),
      .chars_hi  (req_chars_hi),
      .slot_tag  (req_slot_tag),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_word  (dec_word)
   );

   fwofp_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_word   (dec_word),
      .out_valid (mag_valid),
      .out_ready (mag_ready),
      .out_word  (mag_word)
   );

   // Sign stage: negate the magnitude when a minus sign was seen.
   assign value_in = mag_word.side.neg ? -$signed({1'b0, mag_word.mag})
                                       : $signed({1'b0, mag_word.mag});
   assign mag_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (mag_ready) begin
         valid_ff <= mag_valid;
      end
      if (mag_ready && mag_valid) begin
         value_ff <= value_in;
         side_ff  <= mag_word.side;
      end
   end

   // Result word.
   assign rsp_valid        = valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_lli_char     = side_ff.lli_char;
   assign rsp_ssi_char     = side_ff.ssi_char;
   assign rsp_consumed     = side_ff.consumed;
   assign rsp_slot_tag_out = side_ff.slot_tag;

   `FWOFP_ASSERT(a_sign_matches, clock, reset, rsp_valid && (rsp_value != 45'sd0) |-> rsp_value[44] == side_ff.neg)
   `FWOFP_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> !rsp_valid)

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for the fixed-width observation field parser.
`timescale 1ns / 1ps

// One parsed field as the result port presents it.
typedef struct packed {
   logic signed [fwofp_pkg::ValueWidth-1:0] value;
   logic [7:0]                              lli_char;
   logic [7:0]                              ssi_char;
   logic [4:0]                              consumed;
   logic [7:0]                              slot_tag;
} field_parse_type;

// Works out the parse of every accepted field and checks results in order.
class field_parse_scoreboard;
   field_parse_type pending_parses[$];
   int              failures = 0;

   // Blank from the first newline on, then build the signed 13-digit value.
   function field_parse_type parse_field(input logic [63:0] lo, input logic [63:0] hi,
                                         input logic [7:0] tag);
      logic [7:0]      text [fwofp_pkg::FieldBytes];
      int              nl_pos;
      longint unsigned mag;
      logic [3:0]      nib;
      logic            neg;
      logic [fwofp_pkg::ValueWidth-1:0] mag_bits;
      field_parse_type res;
      for (int i = 0; i < 8; i++) begin
         text[i]     = lo[8*i +: 8];
         text[i + 8] = hi[8*i +: 8];
      end
      nl_pos = fwofp_pkg::FieldBytes;
      for (int i = 0; i < fwofp_pkg::FieldBytes; i++) begin
         if (nl_pos == fwofp_pkg::FieldBytes && text[i] == fwofp_pkg::NewlineChar) begin
            nl_pos = i;
         end
         if (nl_pos != fwofp_pkg::FieldBytes) begin
            text[i] = fwofp_pkg::SpaceChar;
         end
      end
      // Digits skip the decimal point byte; high bit or nibble over 9 reads as zero.
      mag = 0;
      for (int i = 0; i < fwofp_pkg::LliByte; i++) begin
         if (i != fwofp_pkg::PointByte) begin
            nib = text[i][3:0];
            if (text[i][7] || nib > 4'd9) begin
               nib = 4'd0;
            end
            mag = mag * 10 + longint'(nib);
         end
      end
      neg = 1'b0;
      for (int i = 0; i < fwofp_pkg::SignBytes; i++) begin
         if (text[i] == fwofp_pkg::MinusChar) begin
            neg = 1'b1;
         end
      end
      mag_bits     = mag[fwofp_pkg::ValueWidth-1:0];
      res.value    = neg ? $signed({fwofp_pkg::ValueWidth{1'b0}} - mag_bits)
                         : $signed(mag_bits);
      res.lli_char = text[fwofp_pkg::LliByte];
      res.ssi_char = text[fwofp_pkg::SsiByte];
      res.consumed = 5'(nl_pos);
      res.slot_tag = tag;
      return res;
   endfunction

   function void note_field(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [7:0] tag);
      pending_parses.push_back(parse_field(lo, hi, tag));
   endfunction

   function void check_result(input field_parse_type got);
      field_parse_type want;
      if (pending_parses.size() == 0) begin
         $error("result word with no field waiting: value %0d tag %0d",
                got.value, got.slot_tag);
         failures++;
         return;
      end
      want = pending_parses.pop_front();
      if (got.value !== want.value) begin
         $error("value: expected %0d, got %0d", want.value, got.value);
         failures++;
      end
      if (got.lli_char !== want.lli_char) begin
         $error("lli_char: expected %h, got %h", want.lli_char, got.lli_char);
         failures++;
      end
      if (got.ssi_char !== want.ssi_char) begin
         $error("ssi_char: expected %h, got %h", want.ssi_char, got.ssi_char);
         failures++;
      end
      if (got.consumed !== want.consumed) begin
         $error("consumed: expected %0d, got %0d", want.consumed, got.consumed);
         failures++;
      end
      if (got.slot_tag !== want.slot_tag) begin
         $error("slot_tag_out: expected %0d, got %0d", want.slot_tag, got.slot_tag);
         failures++;
      end
   endfunction

   function int pending();
      return pending_parses.size();
   endfunction
endclass

module tb_top;

   localparam logic [7:0] ZeroChar   = 8'h30;
   localparam logic [7:0] PointChar  = 8'h2E;
   localparam int         QuietLimit = 2000;
   localparam int         RandomFields = 550;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [63:0]           req_chars_lo = '0;
   logic [63:0]           req_chars_hi = '0;
   logic [7:0]            req_slot_tag = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic signed [44:0]    rsp_value;
   logic [7:0]            rsp_lli_char;
   logic [7:0]            rsp_ssi_char;
   logic [4:0]            rsp_consumed;
   logic [7:0]            rsp_slot_tag_out;

   field_parse_scoreboard sb = new();
   bit                    bursts_on = 1'b0;
   int                    stall_left = 0;
   int                    quiet_cycles = 0;

   fixed_width_observation_field_parse DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_chars_lo     (req_chars_lo),
      .req_chars_hi     (req_chars_hi),
      .req_slot_tag     (req_slot_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value        (rsp_value),
      .rsp_lli_char     (rsp_lli_char),
      .rsp_ssi_char     (rsp_ssi_char),
      .rsp_consumed     (rsp_consumed),
      .rsp_slot_tag_out (rsp_slot_tag_out)
   );

   always #1 clock = ~clock;

   // Result side stalls in random bursts while bursts are enabled.
   always @(posedge clock) begin
      if (stall_left == 0 && bursts_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 11);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Both handshakes are sampled with the values they held before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_field(req_chars_lo, req_chars_hi, req_slot_tag);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{rsp_value, rsp_lli_char, rsp_ssi_char, rsp_consumed,
                              rsp_slot_tag_out});
         end
      end
   end

   // The run ends if neither side moves a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("fixed_width_observation_field_parse test failed");
         $finish;
      end
   end

   // Packs a string into a field, padding with spaces to 16 characters.
   function automatic logic [127:0] text_field(input string s);
      logic [127:0] f;
      f = {16{fwofp_pkg::SpaceChar}};
      for (int i = 0; i < s.len() && i < 16; i++) begin
         f[8*i +: 8] = s[i];
      end
      return f;
   endfunction

   function automatic logic [7:0] digit_char();
      return ZeroChar + 8'($urandom_range(0, 9));
   endfunction

   // Mostly well-formed fields with random digits, sign and newline; some raw noise.
   function automatic logic [127:0] random_field();
      logic [7:0]   text [16];
      logic [127:0] f;
      int           width;
      if ($urandom_range(0, 9) < 2) begin
         return {$urandom, $urandom, $urandom, $urandom};
      end
      for (int i = 0; i < 16; i++) begin
         text[i] = fwofp_pkg::SpaceChar;
      end
      width = $urandom_range(0, 10);
      for (int i = 10 - width; i < 10; i++) begin
         text[i] = digit_char();
      end
      if ($urandom_range(0, 2) == 0) begin
         text[(width == 10) ? 0 : 9 - width] = fwofp_pkg::MinusChar;
      end
      text[fwofp_pkg::PointByte] = PointChar;
      for (int i = 11; i < 14; i++) begin
         text[i] = digit_char();
      end
      text[fwofp_pkg::LliByte] = $urandom_range(0, 1) ? fwofp_pkg::SpaceChar : digit_char();
      text[fwofp_pkg::SsiByte] = $urandom_range(0, 3) == 0 ? fwofp_pkg::SpaceChar
                                                           : digit_char();
      if ($urandom_range(0, 3) == 0) begin
         text[$urandom_range(0, 15)] = fwofp_pkg::NewlineChar;
      end
      if ($urandom_range(0, 5) == 0) begin
         text[$urandom_range(0, 15)] = 8'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
         text[$urandom_range(10, 15)] = fwofp_pkg::MinusChar;
      end
      for (int i = 0; i < 16; i++) begin
         f[8*i +: 8] = text[i];
      end
      return f;
   endfunction

   // Offers one field word and returns at the edge where it is taken.
   task automatic send_field(input logic [127:0] f, input logic [7:0] tag);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_chars_lo <= f[63:0];
      req_chars_hi <= f[127:64];
      req_slot_tag <= tag;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed fields: extremes, sign rules, newline placement, odd bytes.
      bursts_on = 1'b1;
      send_field(text_field(""), 8'd0);
      send_field(text_field("9999999999.99999"), 8'd255);
      send_field(text_field("-999999999.999 9"), 8'd1);
      send_field(text_field("\n99999999.999 1"), 8'd2);
      send_field(text_field("  12345678.90112\n"), 8'd3);
      send_field(text_field("  123\n4-67.123 4"), 8'd4);
      send_field(text_field("--1-2-3-45.678 1"), 8'd5);
      send_field(text_field("        -0.000 0"), 8'd6);
      send_field(text_field("    123456.7-9-5"), 8'd7);
      send_field(text_field("  23619095.450 7"), 8'd8);
      send_field(text_field("12345678-\n123 1"), 8'd9);
      send_field(text_field("1234567890\n1234"), 8'd10);
      send_field(text_field("  1\n2\n3.4\n5 6"), 8'd11);
      send_field(text_field("ABCDEFGHIJ:;<=>?"), 8'd12);
      send_field({16{8'hFF}}, 8'd13);
      send_field({16{8'h00}}, 8'd14);
      send_field({16{8'h8A}}, 8'd15);
      send_field({16{8'hB9}}, 8'd16);
      send_field({8'h2D, 8'h0A, {14{8'h39}}}, 8'd128);
      send_field({{15{8'h37}}, 8'h0A}, 8'd170);
      send_field({16{8'h2D}}, 8'd85);

      // Hold off until the pipeline has drained.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      // Random fields: idle bursts in stretches, none in the last part.
      for (int n = 0; n < RandomFields; n++) begin
         bursts_on = (n < RandomFields - 120) && ((n / 90) % 3 != 2);
         send_field(random_field(), 8'($urandom_range(0, 255)));
      end
      req_valid <= 1'b0;
      bursts_on = 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("fixed_width_observation_field_parse test passed");
      end else begin
         $display("fixed_width_observation_field_parse test failed");
      end
      $finish;
   end

endmodule
